>>> rtl/core/scc_pkg.sv
`default_nettype none
package scc_pkg;
   localparam int unsigned COORD_W    = 24;
   localparam int unsigned DIFF_W     = COORD_W + 1;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned T_W        = FRAC_W + 1;
   localparam int unsigned PROD_W     = 2 * DIFF_W;
   localparam int unsigned SUM_W      = PROD_W + 2;
   localparam int unsigned CORNER_MAX = 4;
   localparam int unsigned REG_COUNT  = 2 * CORNER_MAX;
   localparam int unsigned IDX_W      = $clog2(REG_COUNT);
   localparam int unsigned EDGE_COUNT_DEF = 4;
   localparam logic [T_W-1:0] T_ONE   = T_W'(1) << FRAC_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;

   typedef struct packed {
      coord_type      au;
      coord_type      av;
      diff_type       du;
      diff_type       dv;
      logic [T_W-1:0] t0;
      logic [T_W-1:0] t1;
      logic           rej;
   } seg_type;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] d;
      logic [T_W-1:0]   q;
      logic             fixed;
      logic             skip;
      logic             entry;
   } div_type;

   function automatic coord_type corner_reset(input int unsigned idx);
      coord_type v;
      v = '0;
      case (idx)
         2, 4, 5, 7: v = COORD_W'(T_ONE);
         default:    v = '0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/scc_edge_cell.sv
`default_nettype none
module scc_edge_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    adv,
   input  wire                    in_valid,
   input  scc_pkg::seg_type       in_seg,
   input  scc_pkg::coord_type     e0u,
   input  scc_pkg::coord_type     e0v,
   input  scc_pkg::coord_type     e1u,
   input  scc_pkg::coord_type     e1v,
   output logic                   out_valid,
   output scc_pkg::seg_type       out_seg
);
   import scc_pkg::*;

   localparam int unsigned NST = FRAC_W + 3;

   logic    [NST-1:0] vld_ff;
   seg_type           seg_ff [NST];
   div_type           div_ff [FRAC_W+1];
   logic signed [PROD_W-1:0] p_ff [4];
   logic signed [PROD_W-1:0] p_in [4];
   diff_type nu, nv, ru, rv;
   logic signed [SUM_W-1:0] den, num, nn, dd;
   div_type div_in;
   seg_type seg1_in, fin_in;
   logic [T_W-1:0] tq;

   always_comb begin
      nu = DIFF_W'(e1v) - DIFF_W'(e0v);
      nv = DIFF_W'(e0u) - DIFF_W'(e1u);
      ru = DIFF_W'(e0u) - DIFF_W'(in_seg.au);
      rv = DIFF_W'(e0v) - DIFF_W'(in_seg.av);
      p_in[0] = nu * in_seg.du;
      p_in[1] = nv * in_seg.dv;
      p_in[2] = nu * ru;
      p_in[3] = nv * rv;
   end

   always_comb begin
      den = SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]);
      num = SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]);
      nn  = den[SUM_W-1] ? -num : num;
      dd  = den[SUM_W-1] ? -den : den;
      seg1_in = seg_ff[0];
      div_in.d     = dd;
      div_in.r     = nn;
      div_in.q     = '0;
      div_in.entry = den[SUM_W-1];
      div_in.skip  = (den == '0);
      div_in.fixed = 1'b0;
      if (den == '0) begin
         if (num[SUM_W-1]) seg1_in.rej = 1'b1;
      end else if (nn[SUM_W-1] || nn == '0) begin
         div_in.fixed = 1'b1;
      end else if (nn >= dd) begin
         div_in.fixed = 1'b1;
         div_in.q     = T_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg_ff[0] <= in_seg;
         for (int k = 0; k < 4; k++) p_ff[k] <= p_in[k];
         seg_ff[1] <= seg1_in;
         div_ff[0] <= div_in;
         seg_ff[NST-1] <= fin_in;
      end
   end

   for (genvar s = 0; s < FRAC_W; s++) begin : g_div
      div_type          st_in;
      logic [SUM_W-1:0] r2;
      always_comb begin
         st_in = div_ff[s];
         r2    = {div_ff[s].r[SUM_W-2:0], 1'b0};
         if (!div_ff[s].fixed && !div_ff[s].skip) begin
            if (r2 >= div_ff[s].d) begin
               st_in.r = r2 - div_ff[s].d;
               st_in.q = {div_ff[s].q[T_W-2:0], 1'b1};
            end else begin
               st_in.r = r2;
               st_in.q = {div_ff[s].q[T_W-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[s+1] <= st_in;
            seg_ff[s+2] <= seg_ff[s+1];
         end
      end
   end

   always_comb begin
      fin_in = seg_ff[NST-2];
      tq = div_ff[FRAC_W].q;
      if (div_ff[FRAC_W].entry && !div_ff[FRAC_W].fixed && div_ff[FRAC_W].r != '0)
         tq = tq + T_W'(1);
      if (!fin_in.rej && !div_ff[FRAC_W].skip) begin
         if (div_ff[FRAC_W].entry) begin
            if (tq > fin_in.t0) fin_in.t0 = tq;
         end else begin
            if (tq < fin_in.t1) fin_in.t1 = tq;
         end
         if (fin_in.t0 > fin_in.t1) fin_in.rej = 1'b1;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_seg   = seg_ff[NST-1];
endmodule
`default_nettype wire

>>> rtl/core/scc_lerp.sv
`default_nettype none
module scc_lerp (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 adv,
   input  wire                 in_valid,
   input  scc_pkg::seg_type    in_seg,
   output logic                out_valid,
   output logic                kept,
   output scc_pkg::coord_type  su,
   output scc_pkg::coord_type  sv,
   output scc_pkg::coord_type  eu,
   output scc_pkg::coord_type  ev
);
   import scc_pkg::*;

   localparam int unsigned MW = DIFF_W + T_W + 1;

   logic [1:0] vld_ff;
   seg_type seg_ff;
   logic signed [MW-1:0] m_ff [4];
   logic signed [MW-1:0] m_in [4];
   logic kept_ff, kept_in;
   coord_type c_ff [4];
   coord_type c_in [4];

   always_comb begin
      m_in[0] = in_seg.du * $signed({1'b0, in_seg.t0});
      m_in[1] = in_seg.dv * $signed({1'b0, in_seg.t0});
      m_in[2] = in_seg.du * $signed({1'b0, in_seg.t1});
      m_in[3] = in_seg.dv * $signed({1'b0, in_seg.t1});
      kept_in = !(seg_ff.rej || seg_ff.t1 <= seg_ff.t0);
      for (int k = 0; k < 4; k++) begin
         c_in[k] = '0;
         if (kept_in)
            c_in[k] = COORD_W'(((m_ff[k] + MW'(32768)) >>> FRAC_W)
                      + MW'((k % 2 == 0) ? seg_ff.au : seg_ff.av));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg_ff <= in_seg;
         for (int k = 0; k < 4; k++) begin
            m_ff[k] <= m_in[k];
            c_ff[k] <= c_in[k];
         end
         kept_ff <= kept_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign kept = kept_ff;
   assign su = c_ff[0];
   assign sv = c_ff[1];
   assign eu = c_ff[2];
   assign ev = c_ff[3];
endmodule
`default_nettype wire

>>> rtl/core/segment_clip_convex_polygon.sv
// Cyrus-Beck clip of a Q8.16 segment against a convex CCW polygon of
// EDGE_COUNT (3 or 4) corners held in csr registers 0..7 (u,v pairs).
// One word is taken per cycle while rsp is not held; each word passes through
// one cell per edge (products, sums, a 16-stage restoring divider, update)
// and a two-stage interpolation. The whole pipe stalls while rsp is held.
// Corners may only be written while the pipe is empty.
`default_nettype none
module segment_clip_convex_polygon #(
   parameter int unsigned EDGE_COUNT = scc_pkg::EDGE_COUNT_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   // start_u, start_v, end_u, end_v
   input  wire  [95:0]               req_tdata,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // kept, clip_start_u, clip_start_v, clip_end_u, clip_end_v, zero pad
   output logic [103:0]              rsp_tdata,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [scc_pkg::IDX_W-1:0] csr_index,
   input  wire  [23:0]               csr_data
);
   import scc_pkg::*;

   coord_type corner_ff [REG_COUNT];
   logic adv;
   logic    vld [EDGE_COUNT+1];
   seg_type seg [EDGE_COUNT+1];
   logic kept;
   coord_type su, sv, eu, ev;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < REG_COUNT; k++) corner_ff[k] <= corner_reset(k);
      end else if (csr_valid) begin
         corner_ff[csr_index] <= csr_data;
      end
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      vld[0]    = req_tvalid;
      seg[0].au = req_tdata[23:0];
      seg[0].av = req_tdata[47:24];
      seg[0].du = DIFF_W'($signed(req_tdata[71:48])) - DIFF_W'($signed(req_tdata[23:0]));
      seg[0].dv = DIFF_W'($signed(req_tdata[95:72])) - DIFF_W'($signed(req_tdata[47:24]));
      seg[0].t0 = '0;
      seg[0].t1 = T_ONE;
      seg[0].rej = 1'b0;
   end

   for (genvar i = 0; i < EDGE_COUNT; i++) begin : g_edge
      localparam int unsigned J = (i + 1) % EDGE_COUNT;
      scc_edge_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (vld[i]),
         .in_seg    (seg[i]),
         .e0u       (corner_ff[2*i]),
         .e0v       (corner_ff[2*i+1]),
         .e1u       (corner_ff[2*J]),
         .e1v       (corner_ff[2*J+1]),
         .out_valid (vld[i+1]),
         .out_seg   (seg[i+1])
      );
   end

   scc_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld[EDGE_COUNT]),
      .in_seg    (seg[EDGE_COUNT]),
      .out_valid (rsp_tvalid),
      .kept      (kept),
      .su        (su),
      .sv        (sv),
      .eu        (eu),
      .ev        (ev)
   );

   assign rsp_tdata = {7'b0, ev, eu, sv, su, kept};

`ifndef ASSERT_OFF
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !kept |-> rsp_tdata[96:1] == '0)
      else $error("rejected word carries coordinates");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pipe moved during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");
`endif
endmodule
`default_nettype wire

>>> sim/segment_clip_convex_polygon_test.sv
`default_nettype none
module segment_clip_convex_polygon_test;
   timeunit 1ns;
   timeprecision 1ps;
   import scc_pkg::*;

   localparam int EDGES = EDGE_COUNT_DEF;
   localparam int DRAIN_CYCLES = EDGES * 19 + 30;
   localparam longint CMAX = 8388607;
   localparam longint CMIN = -8388608;

   typedef struct {
      bit      kept;
      longint  su, sv, eu, ev;
   } clip_type;

   class clip_scoreboard;
      longint   corner[REG_COUNT];
      clip_type pending[$];
      int       errors, checked, kept_cnt, rejected_cnt;

      function new();
         corner = '{0, 0, 65536, 0, 65536, 65536, 0, 65536};
      endfunction

      function void write_corner(int idx, logic [23:0] val);
         if (idx < REG_COUNT) corner[idx] = longint'($signed(val));
      endfunction

      function longint frac_step(longint n, longint d, bit up);
         bit [127:0] p;
         bit [127:0] q;
         if (n <= 0) return 0;
         if (n >= d) return 65536;
         p = 128'(n) << 16;
         q = p / 128'(d);
         if (up && (p % 128'(d)) != 0) q = q + 1;
         return longint'(q);
      endfunction

      function longint lerp(longint a, longint d, longint t);
         longint x;
         x = d * t + 32768;
         return a + (x >>> 16);
      endfunction

      function void note(logic [95:0] w);
         longint au, av, du, dv, t0, t1, nu, nv, den, num, t;
         longint e0u, e0v, e1u, e1v;
         bit rej;
         clip_type c;
         int j;
         au = $signed(w[23:0]);
         av = $signed(w[47:24]);
         du = longint'($signed(w[71:48])) - au;
         dv = longint'($signed(w[95:72])) - av;
         t0 = 0;
         t1 = 65536;
         rej = 0;
         for (int i = 0; i < EDGES; i++) begin
            j = (i + 1) % EDGES;
            e0u = corner[2*i];
            e0v = corner[2*i+1];
            e1u = corner[2*j];
            e1v = corner[2*j+1];
            nu = e1v - e0v;
            nv = e0u - e1u;
            den = nu * du + nv * dv;
            num = nu * (e0u - au) + nv * (e0v - av);
            if (den == 0) begin
               if (num < 0) begin
                  rej = 1;
                  break;
               end
               continue;
            end
            if (den < 0) begin
               t = frac_step(-num, -den, 1);
               if (t > t0) t0 = t;
            end else begin
               t = frac_step(num, den, 0);
               if (t < t1) t1 = t;
            end
            if (t0 > t1) begin
               rej = 1;
               break;
            end
         end
         if (t1 - t0 < 1) rej = 1;
         c.kept = !rej;
         if (rej) begin
            c.su = 0; c.sv = 0; c.eu = 0; c.ev = 0;
         end else begin
            c.su = lerp(au, du, t0);
            c.sv = lerp(av, dv, t0);
            c.eu = lerp(au, du, t1);
            c.ev = lerp(av, dv, t1);
         end
         pending = {pending, c};
      endfunction

      task report_mismatch(string what, longint got, longint want);
         errors++;
         $display("mismatch word %0d %s: got %0d expected %0d", checked, what, got, want);
      endtask

      task check(logic [103:0] w);
         clip_type c;
         if (pending.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
            return;
         end
         c = pending.pop_front();
         if (c.kept) kept_cnt++;
         else rejected_cnt++;
         if (w[0] !== c.kept) report_mismatch("kept", w[0], c.kept);
         if ($signed(w[24:1]) !== 24'(c.su))
            report_mismatch("clip_start_u", $signed(w[24:1]), c.su);
         if ($signed(w[48:25]) !== 24'(c.sv))
            report_mismatch("clip_start_v", $signed(w[48:25]), c.sv);
         if ($signed(w[72:49]) !== 24'(c.eu))
            report_mismatch("clip_end_u", $signed(w[72:49]), c.eu);
         if ($signed(w[96:73]) !== 24'(c.ev))
            report_mismatch("clip_end_v", $signed(w[96:73]), c.ev);
         checked++;
      endtask
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, csr_valid, csr_ready;
   logic [95:0] req_tdata;
   logic [103:0] rsp_tdata;
   logic [IDX_W-1:0] csr_index;
   logic [23:0] csr_data;

   clip_scoreboard sb = new();
   int burst_left, stall_mode, stall_left, sent;
   longint span, cen_u, cen_v;

   segment_clip_convex_polygon DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("segment_clip_convex_polygon_test: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 300);
      end else stall_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         2: rsp_tready <= ($urandom_range(0, 15) == 0);
         default: rsp_tready <= stall_left[3];
      endcase
   end

   function automatic longint clamp24(longint x);
      if (x > CMAX) return CMAX;
      if (x < CMIN) return CMIN;
      return x;
   endfunction

   task automatic push(input longint su, input longint sv, input longint eu, input longint ev);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {24'(ev), 24'(eu), 24'(sv), 24'(su)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(req_tdata);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input int idx, input longint val);
      csr_valid <= 1'b1;
      csr_index <= IDX_W'(idx);
      csr_data <= 24'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_corner(idx, 24'(val));
   endtask

   task automatic set_poly(input longint c[8]);
      longint lo_u, hi_u, lo_v, hi_v;
      drain();
      for (int i = 0; i < 8; i++) write_csr(i, c[i]);
      csr_valid <= 1'b0;
      lo_u = c[0]; hi_u = c[0]; lo_v = c[1]; hi_v = c[1];
      for (int i = 1; i < 4; i++) begin
         if (c[2*i] < lo_u) lo_u = c[2*i];
         if (c[2*i] > hi_u) hi_u = c[2*i];
         if (c[2*i+1] < lo_v) lo_v = c[2*i+1];
         if (c[2*i+1] > hi_v) hi_v = c[2*i+1];
      end
      cen_u = (lo_u + hi_u) / 2;
      cen_v = (lo_v + hi_v) / 2;
      span = (hi_u - lo_u > hi_v - lo_v) ? hi_u - lo_u : hi_v - lo_v;
      if (span < 16) span = 16;
   endtask

   function automatic longint near(longint c);
      return clamp24(c - span + longint'($urandom_range(0, 32'(2 * span))));
   endfunction

   function automatic longint any24();
      return longint'($signed(24'($urandom)));
   endfunction

   task automatic random_items(input int n, input bit pause_mid);
      longint su, sv, eu, ev;
      int k;
      for (int i = 0; i < n; i++) begin
         if (pause_mid && i == n / 2) drain();
         k = $urandom_range(0, 19);
         su = near(cen_u); sv = near(cen_v); eu = near(cen_u); ev = near(cen_v);
         if (k < 2) eu = su;
         else if (k < 4) ev = sv;
         else if (k == 4) begin
            eu = su; ev = sv;
         end else if (k > 16) begin
            su = any24(); sv = any24(); eu = any24(); ev = any24();
         end
         push(su, sv, eu, ev);
      end
   endtask

   function automatic longint rnd_in(longint lo, longint hi);
      return lo + longint'($urandom_range(0, 32'(hi - lo)));
   endfunction

   task automatic random_rect(input longint maxh);
      longint h, k, cu, cv;
      h = rnd_in(1, maxh);
      k = rnd_in(1, maxh);
      cu = rnd_in(CMIN + h, CMAX - h);
      cv = rnd_in(CMIN + k, CMAX - k);
      if ($urandom_range(0, 1))
         set_poly('{cu - h, cv - k, cu + h, cv - k, cu + h, cv + k, cu - h, cv + k});
      else
         set_poly('{cu, cv - k, cu + h, cv, cu, cv + k, cu - h, cv});
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      burst_left = 0;
      stall_left = 0;
      sent = 0;
      span = 65536; cen_u = 32768; cen_v = 32768;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit square after reset
      push(16384, 16384, 49152, 49152);
      push(-32768, 32768, 98304, 32768);
      push(32768, -65536, 32768, 131072);
      push(131072, 131072, 196608, 65536);
      push(32768, 32768, 32768, 32768);
      push(131072, 32768, 131072, 32768);
      push(-65536, 131072, 131072, 131072);
      push(0, 0, 65536, 0);
      push(0, 0, 65536, 65536);
      push(CMIN, CMIN, CMAX, CMAX);
      push(CMAX, CMIN, CMIN, CMAX);
      push(CMAX, CMAX, CMIN, CMIN);
      push(65536, 32768, 65537, 32768);
      push(-1, 32768, 0, 32768);
      // full-range square
      set_poly('{CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX});
      push(CMIN, CMIN, CMAX, CMAX);
      push(CMAX, CMIN, CMIN, CMAX);
      push(CMIN, 0, CMAX, 0);
      push(0, 0, 0, 0);
      // triangle: last corner repeats the first, zero-length closing edge
      set_poly('{0, 0, 131072, 0, 0, 131072, 0, 0});
      push(-65536, 32768, 196608, 32768);
      push(32768, 32768, 32768, 32768);
      push(131072, 131072, 131072, 131072);
      push(-65536, -65536, 131072, 131072);

      random_items(240, 1'b1);
      set_poly('{0, 0, 65536, 0, 65536, 65536, 0, 65536});
      random_items(240, 1'b0);
      for (int p = 0; p < 5; p++) begin
         random_rect(p < 2 ? 64 : 2000000);
         random_items(220, p == 3);
      end
      set_poly('{any24(), any24(), any24(), any24(), any24(), any24(), any24(), any24()});
      random_items(150, 1'b0);
      set_poly('{0, 0, 0, 196608, 196608, 196608, 196608, 0});
      random_items(150, 1'b0);

      drain();
      $display("%0d segments sent over 11 polygon settings; %0d kept, %0d rejected",
               sent, sb.kept_cnt, sb.rejected_cnt);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("segment_clip_convex_polygon_test: PASS");
      else
         $display("segment_clip_convex_polygon_test: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
